@@ hdl/rpc_pkg.sv @@
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the run-length packet compressor
// Command format between the front and back halves, store write and
// bank release groups, and the state encodings.
// ----------------------------------------------------------------------------
package rpc_pkg;

  // Packet count field; the header byte leaves seven bits for it
  localparam int unsigned CNT_W = 7;

  // Command queue depth between front and back
  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  // Header flag of a run packet
  localparam logic [7:0] RUN_FLAG = 8'h80;

  // Packet being built
  typedef enum logic [1:0] {
    MODE_UNDECIDED = 2'd0,
    MODE_RUN       = 2'd1,
    MODE_LITERAL   = 2'd2
  } mode_e;

  // Front sequencer
  typedef enum logic {
    FR_ACCEPT = 1'b0,
    FR_END    = 1'b1
  } front_state_e;

  // Back sequencer
  typedef enum logic [2:0] {
    BK_IDLE     = 3'd0,
    BK_RUN_HDR  = 3'd1,
    BK_RUN_BYTE = 3'd2,
    BK_LIT_HDR  = 3'd3,
    BK_LIT_BYTE = 3'd4
  } back_state_e;

  typedef enum logic {
    CMD_RUN = 1'b0,
    CMD_LIT = 1'b1
  } cmd_kind_e;

  // One packet to emit
  typedef struct packed {
    cmd_kind_e        kind;
    logic [CNT_W-1:0] cnt;
    logic [7:0]       data;      // run byte
    logic             bank;      // literal bank
    logic             step_end;  // last packet caused by its input
  } cmd_t;

  // Literal store write request
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [CNT_W-1:0] idx;
    logic [7:0]       data;
  } wr_t;

  // Literal bank drained by the back half
  typedef struct packed {
    logic en;
    logic bank;
  } rel_t;

endpackage

@@ hdl/rle_packet_compressor.sv @@
// ----------------------------------------------------------------------------
// rle_packet_compressor: run-length byte-stream compressor
// Front half classifies bytes into packets, back half emits packed words.
// ----------------------------------------------------------------------------
// The block takes one raw byte per cycle while not stalled and emits run
// packets (0x80|count, byte) and literal packets (count, bytes), each at most
// MAX_PACKET long, as 64-bit words of up to eight bytes, earliest byte in bits
// 7:0; out_last marks the final word caused by one input byte. A byte with
// in_last set passes through both front states: the held byte is handled in
// FR_ACCEPT and the closing byte in FR_END. The back half emits one compressed
// byte per cycle unless the output stalls. It takes each packet from the queue
// in BK_IDLE, then steps a run packet through BK_RUN_HDR and BK_RUN_BYTE and a
// literal packet through BK_LIT_HDR and BK_LIT_BYTE, once per literal byte.
// Literal bytes live in two banks of MAX_PACKET bytes, so input keeps flowing
// while one literal drains. Input stalls while the front half is in FR_END,
// when the bank it needs is still being read, when a byte with in_last set
// finds either bank still being read, or when the four-entry command queue is
// full. The literal store needs no clearing after reset.
// ----------------------------------------------------------------------------
module rle_packet_compressor #(
  parameter int unsigned MAX_PACKET = 127
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] out_data_o,
  output logic [3:0]  out_bytes_o,
  output logic        out_last_o
);

  logic          push_valid, push_ready;
  rpc_pkg::cmd_t push_cmd;
  logic          pop_valid, pop_ready;
  rpc_pkg::cmd_t pop_cmd;
  rpc_pkg::wr_t  wr;
  rpc_pkg::rel_t rel;

  // Packet decisions and literal store writes
  rpc_front #(
    .MAX_PACKET(MAX_PACKET)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd),
    .wr_o        (wr),
    .rel_i       (rel)
  );

  // Command queue
  rpc_cmd_fifo u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_cmd_i  (push_cmd),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_cmd_o   (pop_cmd)
  );

  // Packet emission and word packing
  rpc_back #(
    .MAX_PACKET(MAX_PACKET)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_cmd_i  (pop_cmd),
    .wr_i       (wr),
    .rel_o      (rel),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .out_bytes_o(out_bytes_o),
    .out_last_o (out_last_o)
  );

endmodule

@@ hdl/rpc_front.sv @@
// ----------------------------------------------------------------------------
// rpc_front: input side of the run-length packet compressor
// Holds one byte of lookahead, decides run or literal packets, writes
// literal bytes into the store and queues one command per finished packet.
// ----------------------------------------------------------------------------
module rpc_front #(
  parameter int unsigned MAX_PACKET = 127
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output rpc_pkg::cmd_t push_cmd_o,
  output rpc_pkg::wr_t  wr_o,
  input  rpc_pkg::rel_t rel_i
);

  localparam logic [rpc_pkg::CNT_W-1:0] MaxCnt = rpc_pkg::CNT_W'(MAX_PACKET);

  rpc_pkg::front_state_e    state_q, state_d;
  rpc_pkg::mode_e           mode_q, mode_d;
  logic [rpc_pkg::CNT_W-1:0] count_q, count_d;
  logic [7:0]               held_q, held_d;
  logic                     held_valid_q, held_valid_d;
  logic                     bank_q, bank_d;
  logic [1:0]               busy_q, busy_d;

  logic                     act;
  logic                     at_end;
  logic                     step_end;
  logic                     accept;
  logic [rpc_pkg::CNT_W-1:0] cnt1;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rpc_pkg::FR_ACCEPT;
      mode_q       <= rpc_pkg::MODE_UNDECIDED;
      count_q      <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      bank_q       <= 1'b0;
      busy_q       <= '0;
    end else begin
      state_q      <= state_d;
      mode_q       <= mode_d;
      count_q      <= count_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      bank_q       <= bank_d;
      busy_q       <= busy_d;
    end
  end

  assign cnt1   = count_q + rpc_pkg::CNT_W'(1);
  assign at_end = (state_q == rpc_pkg::FR_END);

  // Sequencing, packet decisions and command generation
  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    count_d      = count_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    bank_d       = bank_q;
    busy_d       = busy_q;
    in_ready_o   = 1'b0;
    accept       = 1'b0;
    act          = 1'b0;
    step_end     = 1'b1;
    push_valid_o = 1'b0;
    push_cmd_o   = '0;
    wr_o         = '0;

    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    unique case (state_q)
      rpc_pkg::FR_ACCEPT: begin
        // an end mark needs both literal banks free for the closing packet
        in_ready_o = push_ready_i && !busy_q[bank_q] &&
                     (!in_last_i || !busy_q[~bank_q]);
        accept     = in_valid_i && in_ready_o;
        act        = accept && held_valid_q;
        step_end   = !in_last_i;
      end
      rpc_pkg::FR_END: begin
        act      = push_ready_i;
        step_end = 1'b1;
      end
      default: ;
    endcase

    // Handle the held byte against its lookahead (or the end mark)
    if (act) begin
      push_cmd_o.data     = held_q;
      push_cmd_o.bank     = bank_q;
      push_cmd_o.step_end = step_end;
      wr_o.bank           = bank_q;
      wr_o.data           = held_q;
      unique case (mode_q)
        rpc_pkg::MODE_RUN: begin
          count_d = cnt1;
          if (at_end || held_q != in_byte_i || cnt1 >= MaxCnt) begin
            push_valid_o    = 1'b1;
            push_cmd_o.kind = rpc_pkg::CMD_RUN;
            push_cmd_o.cnt  = cnt1;
            mode_d          = rpc_pkg::MODE_UNDECIDED;
          end
        end
        rpc_pkg::MODE_LITERAL: begin
          if (at_end || held_q != in_byte_i) begin
            wr_o.en  = 1'b1;
            wr_o.idx = count_q;
            count_d  = cnt1;
            if (cnt1 >= MaxCnt || at_end) begin
              push_valid_o    = 1'b1;
              push_cmd_o.kind = rpc_pkg::CMD_LIT;
              push_cmd_o.cnt  = cnt1;
              busy_d[bank_q]  = 1'b1;
              bank_d          = ~bank_q;
              mode_d          = rpc_pkg::MODE_UNDECIDED;
            end
          end else begin
            // literal closes, a run starts with this byte
            push_valid_o    = 1'b1;
            push_cmd_o.kind = rpc_pkg::CMD_LIT;
            push_cmd_o.cnt  = count_q;
            busy_d[bank_q]  = 1'b1;
            bank_d          = ~bank_q;
            mode_d          = rpc_pkg::MODE_RUN;
            count_d         = rpc_pkg::CNT_W'(1);
          end
        end
        default: begin
          count_d = rpc_pkg::CNT_W'(1);
          if (!at_end && held_q == in_byte_i) begin
            mode_d = rpc_pkg::MODE_RUN;
          end else begin
            wr_o.en  = 1'b1;
            wr_o.idx = '0;
            if (at_end) begin
              // lone byte at end of data: one-byte literal packet
              push_valid_o    = 1'b1;
              push_cmd_o.kind = rpc_pkg::CMD_LIT;
              push_cmd_o.cnt  = rpc_pkg::CNT_W'(1);
              busy_d[bank_q]  = 1'b1;
              bank_d          = ~bank_q;
              mode_d          = rpc_pkg::MODE_UNDECIDED;
            end else begin
              mode_d = rpc_pkg::MODE_LITERAL;
            end
          end
        end
      endcase
    end

    // Lookahead register and end-of-stream cleanup
    if (accept) begin
      held_d       = in_byte_i;
      held_valid_d = 1'b1;
      if (in_last_i) begin
        state_d = rpc_pkg::FR_END;
      end
    end else if (at_end && act) begin
      held_d       = '0;
      held_valid_d = 1'b0;
      mode_d       = rpc_pkg::MODE_UNDECIDED;
      count_d      = '0;
      state_d      = rpc_pkg::FR_ACCEPT;
    end
  end

endmodule

@@ hdl/rpc_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// rpc_cmd_fifo: packet command queue
// Small circular buffer that lets the front and back halves stall apart.
// ----------------------------------------------------------------------------
module rpc_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rpc_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rpc_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned PtrW = rpc_pkg::CMDQ_PTR_W;
  localparam int unsigned CntW = PtrW + 1;
  localparam logic [CntW-1:0] Depth = CntW'(rpc_pkg::CMDQ_DEPTH);

  rpc_pkg::cmd_t        entry_q [rpc_pkg::CMDQ_DEPTH];
  logic [PtrW-1:0]      wptr_q, wptr_d;
  logic [PtrW-1:0]      rptr_q, rptr_d;
  logic [CntW-1:0]      fill_q, fill_d;
  logic                 do_push, do_pop;

  assign push_ready_o = (fill_q != Depth);
  assign pop_valid_o  = (fill_q != '0);
  assign pop_cmd_o    = entry_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointer and fill updates
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(rpc_pkg::CMDQ_DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(rpc_pkg::CMDQ_DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ hdl/rpc_back.sv @@
// ----------------------------------------------------------------------------
// rpc_back: output side of the run-length packet compressor
// Executes packet commands one byte per cycle unless stalled, reads literal
// bytes from the two-bank store and packs each input's bytes in 64-bit words.
// ----------------------------------------------------------------------------
module rpc_back #(
  parameter int unsigned MAX_PACKET = 127
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  rpc_pkg::cmd_t pop_cmd_i,
  input  rpc_pkg::wr_t  wr_i,
  output rpc_pkg::rel_t rel_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [63:0]   out_data_o,
  output logic [3:0]    out_bytes_o,
  output logic          out_last_o
);

  localparam int unsigned IdxW = $clog2(MAX_PACKET);

  rpc_pkg::back_state_e      state_q, state_d;
  rpc_pkg::cmd_t             cmd_q, cmd_d;
  logic [rpc_pkg::CNT_W-1:0] idx_q, idx_d;
  logic [7:0][7:0]           acc_q, acc_d;
  logic [2:0]                acc_n_q, acc_n_d;
  logic                      out_valid_q, out_valid_d;
  logic [63:0]               out_data_q;
  logic [3:0]                out_bytes_q;
  logic                      out_last_q;

  // Literal store: two banks, one write and one registered read per cycle
  logic [7:0]                mem [2][MAX_PACKET];
  logic [7:0]                rd_data_q;
  logic                      rd_en;
  logic                      rd_bank;
  logic [rpc_pkg::CNT_W-1:0] rd_idx;

  logic                      append;
  logic [7:0]                abyte;
  logic                      fin;
  logic                      will_flush;
  logic                      can_step;
  logic [7:0][7:0]           acc_ins;
  logic                      lit_done;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.bank][wr_i.idx[IdxW-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_bank][rd_idx[IdxW-1:0]];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rpc_pkg::BK_IDLE;
      acc_n_q     <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_n_q     <= acc_n_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    idx_q <= idx_d;
    if (append && will_flush) begin
      out_data_q  <= acc_ins;
      out_bytes_q <= {1'b0, acc_n_q} + 4'd1;
      out_last_q  <= fin;
    end
  end

  assign lit_done = (idx_q + rpc_pkg::CNT_W'(1) == cmd_q.cnt);

  // Byte selection for the current step
  always_comb begin
    abyte = '0;
    fin   = 1'b0;
    unique case (state_q)
      rpc_pkg::BK_RUN_HDR:  abyte = rpc_pkg::RUN_FLAG | {1'b0, cmd_q.cnt};
      rpc_pkg::BK_RUN_BYTE: begin
        abyte = cmd_q.data;
        fin   = cmd_q.step_end;
      end
      rpc_pkg::BK_LIT_HDR:  abyte = {1'b0, cmd_q.cnt};
      rpc_pkg::BK_LIT_BYTE: begin
        abyte = rd_data_q;
        fin   = cmd_q.step_end && lit_done;
      end
      default: ;
    endcase
    will_flush = (acc_n_q == 3'd7) || fin;
    can_step   = !will_flush || !out_valid_q || out_ready_i;
    acc_ins    = acc_q;
    acc_ins[acc_n_q] = abyte;
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    pop_ready_o = 1'b0;
    append      = 1'b0;
    rd_en       = 1'b0;
    rd_bank     = cmd_q.bank;
    rd_idx      = '0;
    rel_o       = '0;

    unique case (state_q)
      rpc_pkg::BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          cmd_d   = pop_cmd_i;
          state_d = (pop_cmd_i.kind == rpc_pkg::CMD_RUN) ? rpc_pkg::BK_RUN_HDR
                                                         : rpc_pkg::BK_LIT_HDR;
        end
      end
      rpc_pkg::BK_RUN_HDR: begin
        if (can_step) begin
          append  = 1'b1;
          state_d = rpc_pkg::BK_RUN_BYTE;
        end
      end
      rpc_pkg::BK_RUN_BYTE: begin
        if (can_step) begin
          append  = 1'b1;
          state_d = rpc_pkg::BK_IDLE;
        end
      end
      rpc_pkg::BK_LIT_HDR: begin
        if (can_step) begin
          append  = 1'b1;
          rd_en   = 1'b1;
          idx_d   = '0;
          state_d = rpc_pkg::BK_LIT_BYTE;
        end
      end
      rpc_pkg::BK_LIT_BYTE: begin
        if (can_step) begin
          append = 1'b1;
          if (lit_done) begin
            rel_o.en   = 1'b1;
            rel_o.bank = cmd_q.bank;
            state_d    = rpc_pkg::BK_IDLE;
          end else begin
            rd_en  = 1'b1;
            rd_idx = idx_q + rpc_pkg::CNT_W'(1);
            idx_d  = idx_q + rpc_pkg::CNT_W'(1);
          end
        end
      end
      default: state_d = rpc_pkg::BK_IDLE;
    endcase
  end

  // Word packing and output register
  always_comb begin
    acc_d       = acc_q;
    acc_n_d     = acc_n_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (append) begin
      if (will_flush) begin
        acc_d       = '0;
        acc_n_d     = '0;
        out_valid_d = 1'b1;
      end else begin
        acc_d   = acc_ins;
        acc_n_d = acc_n_q + 3'd1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_bytes_o = out_bytes_q;
  assign out_last_o  = out_last_q;

endmodule

@@ tb/tb_rle_packet_compressor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rle_packet_compressor: self-checking bench for the run-length compressor
// Byte requests stream in from a queue; every accepted byte is run through a
// local packet model, and the words it should produce are checked in order
// against the output channel. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_rle_packet_compressor;

  localparam int unsigned MAX_PACKET = 127;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned ITEM_TARGET = 200;
  localparam int unsigned QUIET_TAIL = 40;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One byte request, or a marker that holds the sender until all words are out
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       hold;
  } byte_req_t;

  // One output word
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_data;
  logic [3:0]  out_bytes;
  logic        out_last;

  rle_packet_compressor #(
    .MAX_PACKET(MAX_PACKET)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_byte_i  (in_byte),
    .in_last_i  (in_last),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .out_bytes_o(out_bytes),
    .out_last_o (out_last)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  byte_req_t   pend_reqs[$];
  word_t       exp_words[$];
  int unsigned n_items = 0;
  int unsigned n_errors = 0;
  int unsigned n_cycles = 0;
  logic [7:0]  last_pushed = '0;

  // --------------------------------------------------------------------------
  // Packet model: state of the compressor as seen from outside
  // --------------------------------------------------------------------------
  logic [7:0]                pk_held = '0;
  logic                      pk_held_ok = 1'b0;
  rpc_pkg::mode_e            pk_mode = rpc_pkg::MODE_UNDECIDED;
  logic [rpc_pkg::CNT_W-1:0] pk_count = '0;
  logic [7:0]                lit_bytes[128];
  logic [7:0]                step_bytes[$];

  function automatic void flush_literal();
    if (pk_count == 0) return;
    step_bytes.push_back({1'b0, pk_count});
    for (int i = 0; i < int'(pk_count); i++) step_bytes.push_back(lit_bytes[i]);
  endfunction

  // Classify byte x given its lookahead nx (none when at_end)
  function automatic void classify_byte(logic [7:0] x, logic [7:0] nx, logic at_end);
    unique case (pk_mode)
      rpc_pkg::MODE_RUN: begin
        pk_count = pk_count + 1'b1;
        if (at_end || x != nx || pk_count >= MAX_PACKET) begin
          step_bytes.push_back(rpc_pkg::RUN_FLAG | {1'b0, pk_count});
          step_bytes.push_back(x);
          pk_mode = rpc_pkg::MODE_UNDECIDED;
        end
      end
      rpc_pkg::MODE_LITERAL: begin
        if (at_end || x != nx) begin
          lit_bytes[pk_count] = x;
          pk_count = pk_count + 1'b1;
          if (pk_count >= MAX_PACKET || at_end) begin
            flush_literal();
            pk_mode = rpc_pkg::MODE_UNDECIDED;
          end
        end else begin
          // a repeat ends the literal and opens a run
          flush_literal();
          pk_mode = rpc_pkg::MODE_RUN;
          pk_count = 1;
        end
      end
      default: begin
        pk_count = 0;
        if (!at_end && x == nx) begin
          pk_count = 1;
          pk_mode = rpc_pkg::MODE_RUN;
        end else begin
          lit_bytes[0] = x;
          pk_count = 1;
          if (at_end) begin
            flush_literal();
            pk_mode = rpc_pkg::MODE_UNDECIDED;
          end else begin
            pk_mode = rpc_pkg::MODE_LITERAL;
          end
        end
      end
    endcase
  endfunction

  // Model one accepted byte and queue the words it produces
  function automatic void compress_step(logic [7:0] b, logic last);
    word_t w;
    int unsigned k;
    step_bytes.delete();
    if (pk_held_ok) classify_byte(pk_held, b, 1'b0);
    if (last) begin
      classify_byte(b, 8'h00, 1'b1);
      pk_held = '0;
      pk_held_ok = 1'b0;
      pk_mode = rpc_pkg::MODE_UNDECIDED;
      pk_count = '0;
    end else begin
      pk_held = b;
      pk_held_ok = 1'b1;
    end
    // pack into words, earliest byte lowest
    k = 0;
    while (k < step_bytes.size()) begin
      w = '0;
      while (w.nbytes < 8 && k < step_bytes.size()) begin
        w.data[8*w.nbytes +: 8] = step_bytes[k];
        w.nbytes++;
        k++;
      end
      w.last = (k == step_bytes.size());
      exp_words.push_back(w);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus builders
  // --------------------------------------------------------------------------
  function automatic void push_req(logic [7:0] b, logic last);
    byte_req_t r;
    r.data = b;
    r.last = last;
    r.hold = 1'b0;
    pend_reqs.push_back(r);
    last_pushed = b;
    n_items++;
  endfunction

  function automatic void push_hold();
    byte_req_t r;
    r.data = '0;
    r.last = 1'b0;
    r.hold = 1'b1;
    pend_reqs.push_back(r);
  endfunction

  function automatic void add_run(logic [7:0] val, int unsigned len);
    repeat (len) push_req(val, 1'b0);
  endfunction

  // neighbors always differ, so this stays a literal
  function automatic void add_literal(int unsigned len);
    logic [7:0] b;
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      while (b == last_pushed) b = 8'($urandom_range(0, 255));
      push_req(b, 1'b0);
    end
  endfunction

  // small alphabet: accidental short runs mixed with literals
  function automatic void add_noise(int unsigned len);
    repeat (len) push_req(8'($urandom_range(0, 3)), 1'b0);
  endfunction

  function automatic void close_stream();
    pend_reqs[pend_reqs.size()-1].last = 1'b1;
  endfunction

  function automatic int unsigned pick_odds();
    unique case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 12;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;
  int unsigned send_odds = 0;
  logic        quiet;

  assign quiet = (pend_reqs.size() < QUIET_TAIL);

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    byte_req_t r;
    logic      took;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
      in_last  <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if ($urandom_range(0, 63) == 0) send_odds = pick_odds();
      if (!in_valid || in_ready) begin
        if (pend_reqs.size() != 0 && pend_reqs[0].hold) begin
          // hold until every word owed so far has come out
          if (!took && exp_words.size() == 0) void'(pend_reqs.pop_front());
          in_valid <= 1'b0;
        end else if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pend_reqs.size() != 0 && !quiet && send_odds != 0 &&
                     $urandom_range(0, send_odds) == 0) begin
          send_gap = $urandom_range(0, 17);
          in_valid <= 1'b0;
        end else if (pend_reqs.size() != 0) begin
          r = pend_reqs.pop_front();
          in_valid <= 1'b1;
          in_byte  <= r.data;
          in_last  <= r.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: model accepted requests, check words, stall the output
  // --------------------------------------------------------------------------
  int unsigned take_gap = 0;
  int unsigned take_odds = 0;

  always @(posedge clk_i or negedge rst_ni) begin : watch_proc
    word_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) compress_step(in_byte, in_last);
      if (out_valid && out_ready) begin
        if (exp_words.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected word, expected none, got data=%h bytes=%0d last=%b",
                   $time, out_data, out_bytes, out_last);
        end else begin
          want = exp_words.pop_front();
          if (out_data !== want.data) begin
            n_errors++;
            $display("%0t: out_data expected %h got %h", $time, want.data, out_data);
          end
          if (out_bytes !== want.nbytes) begin
            n_errors++;
            $display("%0t: out_bytes expected %0d got %0d", $time, want.nbytes, out_bytes);
          end
          if (out_last !== want.last) begin
            n_errors++;
            $display("%0t: out_last expected %b got %b", $time, want.last, out_last);
          end
        end
      end
      if ($urandom_range(0, 63) == 0) take_odds = pick_odds();
      if (take_gap != 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && take_odds != 0 && $urandom_range(0, take_odds) == 0) begin
        take_gap = $urandom_range(0, 17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("tb_rle_packet_compressor NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : main_proc
    int unsigned pick;
    int unsigned len;
    for (int i = 0; i < 128; i++) lit_bytes[i] = '0;

    // lone bytes at end of stream, field extremes
    push_req(8'h00, 1'b1);
    push_req(8'hFF, 1'b1);
    // run closed by the end mark
    push_req(8'hFF, 1'b0);
    push_req(8'hFF, 1'b1);
    // literal closed by the end mark
    push_req(8'h01, 1'b0);
    push_req(8'h02, 1'b0);
    push_req(8'h03, 1'b1);
    // literal broken by a run, then a lone byte
    push_req(8'h10, 1'b0);
    push_req(8'h20, 1'b0);
    push_req(8'h30, 1'b0);
    push_req(8'h30, 1'b0);
    push_req(8'h30, 1'b0);
    push_req(8'h40, 1'b1);
    // run followed by a lone byte at end
    push_req(8'h55, 1'b0);
    push_req(8'h55, 1'b0);
    push_req(8'hAA, 1'b1);
    // alternating header-like values
    push_req(8'h80, 1'b0);
    push_req(8'h7F, 1'b0);
    push_req(8'h80, 1'b0);
    push_req(8'h7F, 1'b1);
    push_hold();

    // packets that hit the length cap, one byte past it
    add_run(8'($urandom_range(0, 255)), MAX_PACKET + 1);
    close_stream();
    add_literal(MAX_PACKET + 1);
    close_stream();
    push_hold();

    // random streams of runs, literals and noise
    while (n_items < ITEM_TARGET) begin
      repeat ($urandom_range(1, 5)) begin
        pick = $urandom_range(0, 9);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 8);
        if (pick < 4) add_run(8'($urandom_range(0, 255)), len);
        else if (pick < 7) add_literal(len);
        else add_noise($urandom_range(1, 6));
      end
      close_stream();
      if ($urandom_range(0, 9) == 0) push_hold();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_reqs.size() != 0 || in_valid || exp_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("tb_rle_packet_compressor OK");
    end else begin
      $display("tb_rle_packet_compressor NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/rpc_pkg.sv
hdl/rpc_front.sv
hdl/rpc_cmd_fifo.sv
hdl/rpc_back.sv
hdl/rle_packet_compressor.sv
tb/tb_rle_packet_compressor.sv
